// ===== hdl/ckd_pkg.sv =====
// Shared types, constants and the square-root step for the chroma key distance mask.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps

package ckd_pkg;

    localparam int PIX_W     = 8;
    localparam int FIX_SHIFT = 14;
    localparam int D2_W      = 18;
    localparam int RES_W     = 9;
    localparam int REM_W     = 11;
    localparam int SQ_STAGES = 3;
    localparam int SQ_STEPS  = 3;
    localparam int LIM_W     = 17;

    localparam logic [13:0] COEF_B2Y = 14'd1868;
    localparam logic [13:0] COEF_G2Y = 14'd9617;
    localparam logic [13:0] COEF_R2Y = 14'd4899;
    localparam logic signed [14:0] COEF_CR = 15'sd11682;
    localparam logic signed [14:0] COEF_CB = 15'sd9241;
    localparam logic [PIX_W-1:0] CHROMA_BIAS = 8'd128;
    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

    localparam logic [PIX_W-1:0] RST_KEY_LUMA  = 8'd0;
    localparam logic [PIX_W-1:0] RST_KEY_CR    = 8'd0;
    localparam logic [PIX_W-1:0] RST_KEY_CB    = 8'd0;
    localparam logic [PIX_W-1:0] RST_THRESHOLD = 8'd20;
    localparam logic [PIX_W-1:0] RST_MASK      = 8'd255;

    typedef enum logic [2:0] {
        CFG_KEY_LUMA  = 3'd0,
        CFG_KEY_CR    = 3'd1,
        CFG_KEY_CB    = 3'd2,
        CFG_THRESHOLD = 3'd3,
        CFG_MASK      = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_b;
        logic [PIX_W-1:0] pixel_g;
        logic [PIX_W-1:0] pixel_r;
    } t_pixel;

    typedef struct packed {
        logic [PIX_W-1:0] mask_out;
        logic [PIX_W-1:0] color_distance;
    } t_result;

    typedef struct packed {
        logic [PIX_W-1:0] cr;
        logic [PIX_W-1:0] cb;
    } t_chroma;

    typedef struct packed {
        logic [D2_W-1:0]  d2;
        logic [RES_W-1:0] res;
        logic [REM_W-1:0] rem;
    } t_sqrt_st;

    // One digit of the restoring square root: bring in two bits of the radicand.
    function automatic t_sqrt_st sqrt_step(input t_sqrt_st st, input logic [1:0] two);
        logic [REM_W+1:0] t;
        logic [REM_W+1:0] trial;
        t_sqrt_st         o;
        t     = {st.rem, two};
        trial = {{(REM_W-RES_W){1'b0}}, st.res, 2'b01};
        o     = st;
        if (t >= trial) begin
            o.rem = REM_W'(t - trial);
            o.res = {st.res[RES_W-2:0], 1'b1};
        end else begin
            o.rem = REM_W'(t);
            o.res = {st.res[RES_W-2:0], 1'b0};
        end
        return o;
    endfunction

endpackage

// ===== hdl/ckd_csc.sv =====
// Two-stage BGR to chroma conversion: luma stage, then clamped Cr and Cb.
// Depends on ckd_pkg.
`timescale 1ns / 1ps

module ckd_csc (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  ckd_pkg::t_pixel   i_pixel,
    output logic              o_valid,
    output ckd_pkg::t_chroma  o_chroma
);
    import ckd_pkg::*;

    function automatic logic [PIX_W-1:0] descale_clamp(input logic signed [23:0] v);
        logic signed [9:0] q;
        q = 10'(v >>> FIX_SHIFT);
        if (v < 0) begin
            return '0;
        end else if (q > $signed({2'b00, PIX_MAX})) begin
            return PIX_MAX;
        end else begin
            return q[PIX_W-1:0];
        end
    endfunction

    logic             r_vld1;
    logic [PIX_W-1:0] r_y;
    logic [PIX_W-1:0] r_r;
    logic [PIX_W-1:0] r_b;
    logic             r_vld2;
    t_chroma          r_chroma;

    logic [22:0]       n_ysum;
    logic [PIX_W-1:0]  n_y;
    logic signed [8:0] n_dr;
    logic signed [8:0] n_db;
    logic signed [23:0] n_cr_fix;
    logic signed [23:0] n_cb_fix;
    t_chroma           n_chroma;

    always_comb begin
        n_ysum = 23'(i_pixel.pixel_b * COEF_B2Y) + 23'(i_pixel.pixel_g * COEF_G2Y)
               + 23'(i_pixel.pixel_r * COEF_R2Y) + 23'(1 << (FIX_SHIFT - 1));
        n_y    = (n_ysum[22:FIX_SHIFT] > 9'(PIX_MAX)) ? PIX_MAX : n_ysum[21:FIX_SHIFT];
    end

    always_comb begin
        n_dr     = $signed({1'b0, r_r}) - $signed({1'b0, r_y});
        n_db     = $signed({1'b0, r_b}) - $signed({1'b0, r_y});
        n_cr_fix = 24'(n_dr * COEF_CR) + $signed({2'b00, CHROMA_BIAS, 14'd0})
                 + $signed(24'(1 << (FIX_SHIFT - 1)));
        n_cb_fix = 24'(n_db * COEF_CB) + $signed({2'b00, CHROMA_BIAS, 14'd0})
                 + $signed(24'(1 << (FIX_SHIFT - 1)));
        n_chroma.cr = descale_clamp(n_cr_fix);
        n_chroma.cb = descale_clamp(n_cb_fix);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            r_vld1 <= i_valid;
            r_vld2 <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_y <= n_y;
            r_r <= i_pixel.pixel_r;
            r_b <= i_pixel.pixel_b;
        end
        if (r_vld1) begin
            r_chroma <= n_chroma;
        end
    end

    assign o_valid  = r_vld2;
    assign o_chroma = r_chroma;

endmodule

// ===== hdl/ckd_dist.sv =====
// Squared distance to the key colour (chroma terms plus squared key luma), one register stage.
// Depends on ckd_pkg.
`timescale 1ns / 1ps

module ckd_dist (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  ckd_pkg::t_chroma          i_chroma,
    input  logic [ckd_pkg::PIX_W-1:0] i_key_cr,
    input  logic [ckd_pkg::PIX_W-1:0] i_key_cb,
    input  logic [2*ckd_pkg::PIX_W-1:0] i_luma_sq,
    output logic                      o_valid,
    output logic [ckd_pkg::D2_W-1:0]  o_d2
);
    import ckd_pkg::*;

    logic signed [PIX_W:0] n_dcr;
    logic signed [PIX_W:0] n_dcb;
    logic [2*PIX_W-1:0]    n_sq_cr;
    logic [2*PIX_W-1:0]    n_sq_cb;
    logic [D2_W-1:0]       n_d2;
    logic                  r_vld;
    logic [D2_W-1:0]       r_d2;

    always_comb begin
        n_dcr   = $signed({1'b0, i_chroma.cr}) - $signed({1'b0, i_key_cr});
        n_dcb   = $signed({1'b0, i_chroma.cb}) - $signed({1'b0, i_key_cb});
        n_sq_cr = (2*PIX_W)'(n_dcr * n_dcr);
        n_sq_cb = (2*PIX_W)'(n_dcb * n_dcb);
        n_d2    = D2_W'(n_sq_cr) + D2_W'(n_sq_cb) + D2_W'(i_luma_sq);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_d2 <= n_d2;
        end
    end

    assign o_valid = r_vld;
    assign o_d2    = r_d2;

endmodule

// ===== hdl/ckd_sqrt.sv =====
// Pipelined restoring integer square root, three digits per register stage.
// Depends on ckd_pkg (sqrt_step, t_sqrt_st).
`timescale 1ns / 1ps

module ckd_sqrt (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [ckd_pkg::D2_W-1:0]  i_d2,
    output logic                      o_valid,
    output ckd_pkg::t_sqrt_st         o_st
);
    import ckd_pkg::*;

    t_sqrt_st r_st      [SQ_STAGES];
    logic     r_vld     [SQ_STAGES];
    t_sqrt_st n_st      [SQ_STAGES];
    t_sqrt_st stage_in  [SQ_STAGES];
    logic     stage_vld [SQ_STAGES];

    genvar s;
    generate
        for (s = 0; s < SQ_STAGES; s++) begin : g_stage
            if (s == 0) begin : g_head
                assign stage_in[s]  = '{d2: i_d2, res: '0, rem: '0};
                assign stage_vld[s] = i_valid;
            end else begin : g_tail
                assign stage_in[s]  = r_st[s-1];
                assign stage_vld[s] = r_vld[s-1];
            end

            always_comb begin
                t_sqrt_st st;
                st = stage_in[s];
                for (int k = 0; k < SQ_STEPS; k++) begin
                    st = sqrt_step(st, st.d2[2*(RES_W-1-(s*SQ_STEPS+k)) +: 2]);
                end
                n_st[s] = st;
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[s] <= 1'b0;
                end else begin
                    r_vld[s] <= stage_vld[s];
                end
            end

            always_ff @(posedge i_clk) begin
                r_st[s] <= n_st[s];
            end
        end
    endgenerate

    assign o_valid = r_vld[SQ_STAGES-1];
    assign o_st    = r_st[SQ_STAGES-1];

endmodule

// ===== hdl/chroma_key_distance_mask.sv =====
// Top level: configuration registers, pipeline chain and output register.
// Depends on ckd_pkg, ckd_csc, ckd_dist, ckd_sqrt.
//
// Channel   Direction  Handshake                   Payload
// pixel     in         start high, busy low        i_pixel (t_pixel)
// result    out        o_strobe, one cycle         o_result (t_result)
// config    in         i_cfg_valid & o_cfg_ready   i_cfg_index, i_cfg_data
//
// One pixel transaction is taken every clock cycle; busy stays low.
// Each result passes two conversion stages, one squared-distance stage,
// three square-root stages and one output register.
// Reset clears valid bits and loads register defaults; no clearing pass.
// The receiver cannot stall, so the pipeline advances every cycle.
`timescale 1ns / 1ps

module chroma_key_distance_mask (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  ckd_pkg::t_pixel           i_pixel,
    output logic                      o_strobe,
    output ckd_pkg::t_result          o_result,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  ckd_pkg::t_cfg_idx         i_cfg_index,
    input  logic [ckd_pkg::PIX_W-1:0] i_cfg_data
);
    import ckd_pkg::*;

    logic [PIX_W-1:0]   r_key_luma;
    logic [PIX_W-1:0]   r_key_cr;
    logic [PIX_W-1:0]   r_key_cb;
    logic [PIX_W-1:0]   r_threshold;
    logic [PIX_W-1:0]   r_mask;
    logic [2*PIX_W-1:0] r_luma_sq;
    logic [LIM_W-1:0]   r_lim;
    logic [PIX_W:0]     n_th1;

    logic             csc_vld;
    t_chroma          csc_chroma;
    logic             dist_vld;
    logic [D2_W-1:0]  dist_d2;
    logic             sq_vld;
    t_sqrt_st         sq_st;

    logic             r_strobe;
    t_result          r_result;
    t_result          n_result;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_luma  <= RST_KEY_LUMA;
            r_key_cr    <= RST_KEY_CR;
            r_key_cb    <= RST_KEY_CB;
            r_threshold <= RST_THRESHOLD;
            r_mask      <= RST_MASK;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_KEY_LUMA:  r_key_luma  <= i_cfg_data;
                CFG_KEY_CR:    r_key_cr    <= i_cfg_data;
                CFG_KEY_CB:    r_key_cb    <= i_cfg_data;
                CFG_THRESHOLD: r_threshold <= i_cfg_data;
                CFG_MASK:      r_mask      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign n_th1 = {1'b0, r_threshold} + (PIX_W+1)'(1);

    always_ff @(posedge i_clk) begin
        r_luma_sq <= (2*PIX_W)'(r_key_luma * r_key_luma);
        r_lim     <= LIM_W'(n_th1 * n_th1);
    end

    ckd_csc u_csc (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (start && !busy),
        .i_pixel  (i_pixel),
        .o_valid  (csc_vld),
        .o_chroma (csc_chroma)
    );

    ckd_dist u_dist (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (csc_vld),
        .i_chroma  (csc_chroma),
        .i_key_cr  (r_key_cr),
        .i_key_cb  (r_key_cb),
        .i_luma_sq (r_luma_sq),
        .o_valid   (dist_vld),
        .o_d2      (dist_d2)
    );

    ckd_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dist_vld),
        .i_d2    (dist_d2),
        .o_valid (sq_vld),
        .o_st    (sq_st)
    );

    always_comb begin
        n_result.color_distance = (sq_st.res > RES_W'(PIX_MAX)) ? PIX_MAX
                                                                : sq_st.res[PIX_W-1:0];
        n_result.mask_out       = (sq_st.d2 < D2_W'(r_lim)) ? r_mask : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= sq_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (sq_vld) begin
            r_result <= n_result;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for chroma_key_distance_mask: a directed plan of pixels and
// register writes, then random phases scored against a predictor kept in step here.
// Depends on ckd_pkg and the chroma_key_distance_mask RTL.
`timescale 1ns / 1ps

module tb;
    import ckd_pkg::*;

    localparam logic [2:0] CFG_SPARE_LO = 3'd5;
    localparam logic [2:0] CFG_SPARE_HI = 3'd7;
    localparam int PIPE_DRAIN = 12;
    localparam int PHASES = 8;
    localparam int PHASE_PIXELS = 150;

    typedef enum logic {ROW_PIXEL, ROW_WRITE} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        logic [2:0]  reg_idx;
        logic [7:0]  reg_data;
        t_pixel      px;
        bit          checked;
        t_result     want;
    } t_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    t_pixel     i_pixel = '0;
    logic       o_strobe;
    t_result    o_result;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    t_cfg_idx   i_cfg_index = CFG_KEY_LUMA;
    logic [7:0] i_cfg_data = '0;

    logic [7:0] key_y = RST_KEY_LUMA;
    logic [7:0] key_cr = RST_KEY_CR;
    logic [7:0] key_cb = RST_KEY_CB;
    logic [7:0] match_limit = RST_THRESHOLD;
    logic [7:0] match_level = RST_MASK;

    t_result pending_results[$];
    t_row    plan[$];
    int      mismatches = 0;
    bit      quiet = 1'b0;

    chroma_key_distance_mask dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_pixel     (i_pixel),
        .o_strobe    (o_strobe),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    initial begin
        #5_000_000;
        $display("chroma_key_distance_mask: mismatch");
        $finish;
    end

    task automatic note_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("[%0t] %s: got %0d, want %0d", $time, what, got, want);
    endtask

    function automatic logic [7:0] round_clamp(input int v);
        int q;
        q = (v + (1 << (FIX_SHIFT - 1))) >>> FIX_SHIFT;
        if (q < 0) return 8'd0;
        if (q > 255) return 8'd255;
        return q[7:0];
    endfunction

    function automatic t_chroma chroma_of(input t_pixel px);
        int b, g, r, y;
        t_chroma c;
        b = px.pixel_b;
        g = px.pixel_g;
        r = px.pixel_r;
        y = (b * 1868 + g * 9617 + r * 4899 + (1 << (FIX_SHIFT - 1))) >> FIX_SHIFT;
        if (y > 255) y = 255;
        c.cr = round_clamp((r - y) * 11682 + (128 << FIX_SHIFT));
        c.cb = round_clamp((b - y) * 9241 + (128 << FIX_SHIFT));
        return c;
    endfunction

    function automatic int unsigned root_floor(input int unsigned v);
        int unsigned r;
        int unsigned t;
        r = 0;
        for (int k = 9; k >= 0; k--) begin
            t = r | (1 << k);
            if (t * t <= v) r = t;
        end
        return r;
    endfunction

    function automatic t_result mask_for_pixel(input t_pixel px);
        t_chroma     c;
        int          dcr, dcb;
        int unsigned d2, dist_floor, lim;
        t_result     res;
        c   = chroma_of(px);
        dcr = int'(c.cr) - int'(key_cr);
        dcb = int'(c.cb) - int'(key_cb);
        d2  = int'(key_y) * int'(key_y) + dcr * dcr + dcb * dcb;
        dist_floor = root_floor(d2);
        if (dist_floor > 255) dist_floor = 255;
        lim = (int'(match_limit) + 1) * (int'(match_limit) + 1);
        res.mask_out = (d2 < lim) ? match_level : 8'd0;
        res.color_distance = dist_floor[7:0];
        return res;
    endfunction

    function automatic t_row px_row(input logic [7:0] b, g, r);
        t_row row;
        row.kind = ROW_PIXEL;
        row.reg_idx = '0;
        row.reg_data = '0;
        row.px = '{pixel_b: b, pixel_g: g, pixel_r: r};
        row.checked = 1'b0;
        row.want = '0;
        return row;
    endfunction

    function automatic t_row px_chk(input logic [7:0] b, g, r, mask, dist_want);
        t_row row;
        row = px_row(b, g, r);
        row.checked = 1'b1;
        row.want = '{mask_out: mask, color_distance: dist_want};
        return row;
    endfunction

    function automatic t_row wr_row(input logic [2:0] idx, input logic [7:0] data);
        t_row row;
        row = px_row(8'd0, 8'd0, 8'd0);
        row.kind = ROW_WRITE;
        row.reg_idx = idx;
        row.reg_data = data;
        return row;
    endfunction

    function automatic logic [7:0] rand_chan();
        case ($urandom_range(9))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [7:0] jitter(input logic [7:0] c);
        int v;
        v = int'(c) + int'($urandom_range(24)) - 12;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v[7:0];
    endfunction

    task automatic send_pixel(input t_pixel px, input t_result want);
        start <= 1'b1;
        i_pixel <= px;
        do @(posedge i_clk); while (busy);
        pending_results.push_back(want);
        if (!quiet && $urandom_range(99) < 6) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] data);
        if ($urandom_range(99) < 6) repeat ($urandom_range(1, 6)) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= t_cfg_idx'(idx);
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_KEY_LUMA:  key_y = data;
            CFG_KEY_CR:    key_cr = data;
            CFG_KEY_CB:    key_cb = data;
            CFG_THRESHOLD: match_limit = data;
            CFG_MASK:      match_level = data;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_strobe) begin
            if (pending_results.size() == 0) begin
                note_mismatch("result with nothing pending", o_result, -1);
            end else begin
                want = pending_results.pop_front();
                if (o_result.mask_out !== want.mask_out)
                    note_mismatch("mask_out", o_result.mask_out, want.mask_out);
                if (o_result.color_distance !== want.color_distance)
                    note_mismatch("color_distance", o_result.color_distance,
                                  want.color_distance);
            end
        end
    end

    initial begin
        t_chroma seed_c;
        t_pixel  seed, px;
        int      mode;

        // extremes, chroma clamping, exact match, threshold edges, spare indexes
        plan.push_back(px_chk(8'd0, 8'd0, 8'd0, 8'd0, 8'd181));
        plan.push_back(px_chk(8'd255, 8'd255, 8'd255, 8'd0, 8'd181));
        plan.push_back(px_row(8'd0, 8'd0, 8'd255));
        plan.push_back(px_row(8'd255, 8'd0, 8'd0));
        plan.push_back(px_row(8'd0, 8'd255, 8'd0));
        plan.push_back(px_row(8'd255, 8'd255, 8'd0));
        plan.push_back(px_row(8'd0, 8'd255, 8'd255));
        plan.push_back(px_row(8'd128, 8'd128, 8'd128));
        plan.push_back(wr_row(CFG_KEY_CR, 8'd128));
        plan.push_back(wr_row(CFG_KEY_CB, 8'd128));
        plan.push_back(px_chk(8'd0, 8'd0, 8'd0, 8'd255, 8'd0));
        plan.push_back(wr_row(CFG_MASK, 8'd0));
        plan.push_back(px_chk(8'd128, 8'd128, 8'd128, 8'd0, 8'd0));
        plan.push_back(wr_row(CFG_MASK, 8'hA5));
        plan.push_back(wr_row(CFG_THRESHOLD, 8'd0));
        plan.push_back(px_chk(8'd255, 8'd255, 8'd255, 8'hA5, 8'd0));
        plan.push_back(wr_row(CFG_KEY_LUMA, 8'd20));
        plan.push_back(wr_row(CFG_THRESHOLD, 8'd20));
        plan.push_back(px_chk(8'd0, 8'd0, 8'd0, 8'hA5, 8'd20));
        plan.push_back(wr_row(CFG_THRESHOLD, 8'd19));
        plan.push_back(px_chk(8'd0, 8'd0, 8'd0, 8'd0, 8'd20));
        plan.push_back(wr_row(CFG_SPARE_LO, 8'hFF));
        plan.push_back(wr_row(CFG_SPARE_HI, 8'h00));
        plan.push_back(px_chk(8'd0, 8'd0, 8'd0, 8'd0, 8'd20));
        plan.push_back(wr_row(CFG_KEY_LUMA, 8'd255));
        plan.push_back(wr_row(CFG_THRESHOLD, 8'd255));
        plan.push_back(px_chk(8'd0, 8'd0, 8'd0, 8'hA5, 8'd255));
        plan.push_back(wr_row(CFG_KEY_CR, 8'd0));
        plan.push_back(wr_row(CFG_KEY_CB, 8'd0));
        plan.push_back(px_chk(8'd0, 8'd0, 8'd0, 8'd0, 8'd255));
        plan.push_back(px_row(8'd255, 8'd0, 8'd255));
        plan.push_back(wr_row(CFG_KEY_LUMA, 8'd0));
        plan.push_back(px_chk(8'd0, 8'd0, 8'd0, 8'hA5, 8'd181));

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_WRITE) begin
                wait_idle();
                write_reg(plan[i].reg_idx, plan[i].reg_data);
            end else begin
                send_pixel(plan[i].px, plan[i].checked ? plan[i].want
                                                       : mask_for_pixel(plan[i].px));
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            wait_idle();
            mode = p % 3;
            seed = '{pixel_b: rand_chan(), pixel_g: rand_chan(), pixel_r: rand_chan()};
            seed_c = chroma_of(seed);
            case (mode)
                0: begin
                    write_reg(CFG_KEY_LUMA, 8'($urandom_range(255)));
                    write_reg(CFG_KEY_CR, 8'($urandom_range(255)));
                    write_reg(CFG_KEY_CB, 8'($urandom_range(255)));
                    write_reg(CFG_THRESHOLD, 8'($urandom_range(255)));
                    write_reg(CFG_MASK, 8'($urandom_range(255)));
                end
                1: begin
                    write_reg(CFG_KEY_LUMA, $urandom_range(1) ? 8'd255 : 8'd0);
                    write_reg(CFG_KEY_CR, $urandom_range(1) ? 8'd255 : 8'd0);
                    write_reg(CFG_KEY_CB, $urandom_range(1) ? 8'd255 : 8'd0);
                    write_reg(CFG_THRESHOLD, $urandom_range(1) ? 8'd255 : 8'd0);
                    write_reg(CFG_MASK, $urandom_range(1) ? 8'd255 : 8'd0);
                end
                default: begin
                    write_reg(CFG_KEY_LUMA, 8'($urandom_range(15)));
                    write_reg(CFG_KEY_CR, seed_c.cr);
                    write_reg(CFG_KEY_CB, seed_c.cb);
                    write_reg(CFG_THRESHOLD, 8'($urandom_range(40)));
                    write_reg(CFG_MASK, 8'($urandom_range(255)));
                end
            endcase
            if ($urandom_range(2) == 0)
                write_reg(3'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)),
                          8'($urandom_range(255)));

            for (int n = 0; n < PHASE_PIXELS; n++) begin
                quiet = (p == 2 || p == 3);
                if (mode == 2 && $urandom_range(9) < 7)
                    px = '{pixel_b: jitter(seed.pixel_b), pixel_g: jitter(seed.pixel_g),
                           pixel_r: jitter(seed.pixel_r)};
                else
                    px = '{pixel_b: rand_chan(), pixel_g: rand_chan(), pixel_r: rand_chan()};
                send_pixel(px, mask_for_pixel(px));
            end
            quiet = 1'b0;
        end

        wait_idle();
        repeat (PIPE_DRAIN) @(posedge i_clk);
        if (pending_results.size() != 0)
            note_mismatch("results never produced", 0, pending_results.size());
        if (mismatches == 0)
            $display("chroma_key_distance_mask: match");
        else
            $display("chroma_key_distance_mask: mismatch");
        $finish;
    end

endmodule
